// ===== rtl/core/iccp_pkg.sv =====
`default_nettype none

package iccp_pkg;

  // Field widths of the transaction payloads.
  localparam int ICCP_CPU_W   = 6;
  localparam int ICCP_MASK_W  = 64;
  localparam int ICCP_BASE_W  = 13;
  localparam int ICCP_CHOSE_W = 14;

  // Default number of cluster mask entries.
  localparam int ICCP_TABLE_DEPTH = 64;

  // Golden-ratio multiplier used to scatter the round-robin counter.
  localparam logic [31:0] ICCP_HASH_MULT = 32'h9E37_79B9;

  // Function codes carried by the func field.
  localparam logic FUNC_SEARCH = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // input transaction accepted this cycle
    logic latch_cand;  // table entry is on the RAM output
    logic hash;        // scatter the counter
    logic scale;       // map the hash onto a rank
    logic pick;        // find the byte holding the ranked bit
    logic emit;        // load the result register
  } iccp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cand_nz;     // at least one candidate CPU is left
  } iccp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/iccp_ram.sv =====
`default_nettype none

module iccp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/iccp_ctrl.sv =====
`default_nettype none

module iccp_ctrl
  import iccp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      func,
  output logic           out_valid,
  input  wire logic      out_ready,
  output iccp_cmd_t      cmd,
  input  wire iccp_sts_t sts
);

  typedef enum logic [2:0] {
    IDLE,
    READ,
    HASH,
    SCALE,
    PICK,
    EMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   emit_go;

  // Inputs are taken only between searches; a pending result does not block.
  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  // The result register can be loaded once the previous result has gone.
  assign emit_go = (state == EMIT) && (!out_valid || out_ready);

  // Commands are decoded from the state.
  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.latch_cand = (state == READ);
    cmd.hash       = (state == HASH);
    cmd.scale      = (state == SCALE);
    cmd.pick       = (state == PICK);
    cmd.emit       = emit_go;
  end

  // Sequencer and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (accept && func == FUNC_SEARCH) begin
            state <= READ;
          end
        end
        READ: begin
          state <= sts.cand_nz ? HASH : EMIT;
        end
        HASH: begin
          state <= SCALE;
        end
        SCALE: begin
          state <= PICK;
        end
        PICK: begin
          state <= EMIT;
        end
        EMIT: begin
          if (emit_go) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/iccp_dp.sv =====
`default_nettype none

module iccp_dp
  import iccp_pkg::*;
#(
  parameter int TABLE_DEPTH = ICCP_TABLE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire iccp_cmd_t                cmd,
  output iccp_sts_t                     sts,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_wdata,
  input  wire logic                     func,
  input  wire logic [ICCP_CPU_W-1:0]    target_cpu,
  input  wire logic [ICCP_MASK_W-1:0]   mask_word,
  input  wire logic [ICCP_BASE_W-1:0]   cpu_base,
  output logic                          found,
  output logic      [ICCP_CHOSE_W-1:0]  chosen_cpu
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [ICCP_CPU_W:0] DEPTH_LIM = (ICCP_CPU_W + 1)'(TABLE_DEPTH);

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + 4'(b[k]);
    end
    return n;
  endfunction

  logic                   rr_mode;
  logic [31:0]            rr_counter;
  logic [ICCP_MASK_W-1:0] mask_q;
  logic [ICCP_BASE_W-1:0] base_q;
  logic                   in_range;
  logic                   in_range_q;
  logic [ICCP_MASK_W-1:0] rdata;
  logic [ICCP_MASK_W-1:0] cand_c;
  logic [ICCP_MASK_W-1:0] cand;
  logic                   cand_nz;
  logic [3:0]             cnt_c [8];
  logic [3:0]             byte_cnt [8];
  logic [6:0]             total_c;
  logic [6:0]             total;
  logic [31:0]            seed;
  logic [38:0]            scaled;
  logic [5:0]             rank_c;
  logic [5:0]             rank;
  logic [6:0]             acc;
  logic                   hit;
  logic [2:0]             sel_c;
  logic [2:0]             rem_c;
  logic [2:0]             byte_sel;
  logic [2:0]             rem;
  logic [7:0]             sel_byte;
  logic [3:0]             seen;
  logic                   hit_bit;
  logic [2:0]             bit_c;
  logic [5:0]             pos;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rr_mode <= 1'b1;
    end else if (cfg_we) begin
      rr_mode <= cfg_wdata;
    end
  end

  // Indices beyond the table are never written and read as empty.
  assign in_range = {1'b0, target_cpu} < DEPTH_LIM;

  iccp_ram #(
    .WIDTH (ICCP_MASK_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.capture && func == FUNC_LOAD && in_range),
    .waddr (target_cpu[AW-1:0]),
    .wdata (mask_word),
    .raddr (target_cpu[AW-1:0]),
    .rdata (rdata)
  );

  // Hold the search operands while the entry is read.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mask_q     <= mask_word;
      base_q     <= cpu_base;
      in_range_q <= in_range;
    end
  end

  // Candidate mask and its per-byte population counts.
  always_comb begin
    cand_c  = mask_q & (in_range_q ? rdata : '0);
    total_c = '0;
    for (int i = 0; i < 8; i++) begin
      cnt_c[i] = pop8(cand_c[i*8 +: 8]);
      total_c  = total_c + 7'(cnt_c[i]);
    end
  end

  assign sts.cand_nz = |cand_c;

  always_ff @(posedge clk) begin
    if (cmd.latch_cand) begin
      cand     <= cand_c;
      cand_nz  <= |cand_c;
      byte_cnt <= cnt_c;
      total    <= total_c;
    end
  end

  // In round-robin mode, the round-robin counter advances once per successful search.
  always_ff @(posedge clk) begin
    if (rst) begin
      rr_counter <= '0;
    end else if (cmd.latch_cand && (|cand_c) && rr_mode) begin
      rr_counter <= rr_counter + 32'd1;
    end
  end

  // Scatter the counter; only the low word of the product is kept.
  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      seed <= rr_counter * ICCP_HASH_MULT;
    end
  end

  // Multiply-high maps the hash onto a rank below the candidate count.
  // Plain mode takes the lowest bit; with two candidates the counter's
  // low bit chooses.
  assign scaled = 39'(seed) * 39'(total);

  always_comb begin
    if (!rr_mode) begin
      rank_c = '0;
    end else if (total <= 7'd2) begin
      rank_c = {5'b0, (total == 7'd2) && rr_counter[0]};
    end else begin
      rank_c = scaled[37:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      rank <= rank_c;
    end
  end

  // Walk the byte counts to find the byte that holds the ranked bit.
  always_comb begin
    acc   = '0;
    hit   = 1'b0;
    sel_c = '0;
    rem_c = '0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && (acc + 7'(byte_cnt[i])) > 7'(rank)) begin
        hit   = 1'b1;
        sel_c = 3'(i);
        rem_c = 3'(7'(rank) - acc);
      end
      acc = acc + 7'(byte_cnt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      byte_sel <= sel_c;
      rem      <= rem_c;
    end
  end

  // Find the remaining rank within the chosen byte.
  always_comb begin
    sel_byte = cand[{byte_sel, 3'b000} +: 8];
    seen     = '0;
    hit_bit  = 1'b0;
    bit_c    = '0;
    for (int j = 0; j < 8; j++) begin
      if (sel_byte[j]) begin
        if (!hit_bit && seen == {1'b0, rem}) begin
          hit_bit = 1'b1;
          bit_c   = 3'(j);
        end
        seen = seen + 4'd1;
      end
    end
  end

  assign pos = {byte_sel, bit_c};

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found      <= cand_nz;
      chosen_cpu <= cand_nz ? (ICCP_CHOSE_W'(base_q) + ICCP_CHOSE_W'(pos)) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/idle_cpu_cluster_picker_unit.sv =====
// Idle CPU cluster picker.
// Input channel (in_valid/in_ready) carries func, target_cpu, mask_word and
// cpu_base. A load transaction (func = 1) writes mask_word into the cluster
// mask entry of target_cpu and returns nothing. A search transaction
// (func = 0) ANDs mask_word with that entry and returns one result on the
// output channel (out_valid/out_ready): found and chosen_cpu. A search whose
// candidate set is empty goes from the table read straight to the result
// stage; any other search passes through the table read, the hash multiply,
// the scale multiply, the byte walk and the bit select that one shared
// sequence of registers performs in turn. A new transaction is taken in the
// cycle after the previous result is loaded, not while a search is running.
// cfg_we/cfg_wdata write round_robin_mode (1 = hashed round-robin pick,
// 0 = lowest idle bit); the user must do so only while the block is idle,
// as the block itself does not enforce this.
// Reset clears the round-robin counter, sets round-robin mode and drops
// out_valid; table entries hold nothing until loaded. If the receiver stalls,
// the result holds in the output register, one more search may be accepted,
// and it waits before its result stage until the output register is free.
`default_nettype none

module idle_cpu_cluster_picker_unit
  import iccp_pkg::*;
#(
  parameter int TABLE_DEPTH = ICCP_TABLE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     func,
  input  wire logic [ICCP_CPU_W-1:0]    target_cpu,
  input  wire logic [ICCP_MASK_W-1:0]   mask_word,
  input  wire logic [ICCP_BASE_W-1:0]   cpu_base,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          found,
  output logic      [ICCP_CHOSE_W-1:0]  chosen_cpu,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_wdata
);

  iccp_cmd_t cmd;
  iccp_sts_t sts;

  iccp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  iccp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .func       (func),
    .target_cpu (target_cpu),
    .mask_word  (mask_word),
    .cpu_base   (cpu_base),
    .found      (found),
    .chosen_cpu (chosen_cpu)
  );

`ifndef SYNTHESIS
  // A not-found result always reports CPU zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> chosen_cpu == '0)
    else $error("not-found result carries a nonzero CPU number");

  // A search occupies the block for at least the following cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_SEARCH |=> !in_ready)
    else $error("input taken while a search is in progress");

  // The block is ready again in the cycle after a load is accepted.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_LOAD |=> in_ready)
    else $error("load did not return to ready");
`endif

endmodule

`default_nettype wire
